@@ rtl/svpd_pkg.sv @@
`default_nettype none

package svpd_pkg;

    // Fixed bytes ahead of the payload: header, header, length, id, command,
    // check1, check2.
    localparam logic [7:0] HEADER_BYTES = 8'd7;

    localparam logic [7:0] HEADER_VALUE_RST = 8'hFF;
    localparam logic [7:0] CHECK_MASK_RST   = 8'hFE;
    localparam logic [7:0] MAX_LENGTH_RST   = 8'hFF;

    // Configuration register indexes
    localparam logic [1:0] REG_HEADER_VALUE = 2'd0;
    localparam logic [1:0] REG_CHECK_MASK   = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEAD1   = 3'd0,
        PH_HEAD2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_ID      = 3'd3,
        PH_CMD     = 3'd4,
        PH_CHECK1  = 3'd5,
        PH_CHECK2  = 3'd6,
        PH_PAYLOAD = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_HEADER   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] check_mask;
        logic [7:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] command;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       last;
        status_t    status;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/svpd_parser.sv @@
`default_nettype none

module svpd_parser (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           advance,
    input  wire logic [7:0]     rx_byte,
    input  wire svpd_pkg::cfg_t cfg,
    output svpd_pkg::res_t      result,
    output logic                emit
);

    svpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] chk1_reg, chk1_next;
    logic [7:0] chk2_reg, chk2_next;

    logic [7:0]        xor_payload;
    svpd_pkg::status_t sum_status_chk2;
    svpd_pkg::status_t sum_status_pay;

    assign xor_payload = xor_reg ^ rx_byte;

    // Check against the byte arriving now for check2; payload folds in the byte.
    assign sum_status_chk2 = ((chk1_reg == (xor_reg & cfg.check_mask)) &&
                              (rx_byte == (~xor_reg & cfg.check_mask)))
                             ? svpd_pkg::ST_OK : svpd_pkg::ST_CHECKSUM;
    assign sum_status_pay  = ((chk1_reg == (xor_payload & cfg.check_mask)) &&
                              (chk2_reg == (~xor_payload & cfg.check_mask)))
                             ? svpd_pkg::ST_OK : svpd_pkg::ST_CHECKSUM;

    // Next state
    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        id_next         = id_reg;
        cmd_next        = cmd_reg;
        chk1_next       = chk1_reg;
        chk2_next       = chk2_reg;
        unique case (phase_reg)
            svpd_pkg::PH_HEAD1: begin
                phase_next = (rx_byte == cfg.header_value) ? svpd_pkg::PH_HEAD2
                                                            : svpd_pkg::PH_HEAD1;
            end
            svpd_pkg::PH_HEAD2: begin
                phase_next = (rx_byte == cfg.header_value) ? svpd_pkg::PH_LENGTH
                                                            : svpd_pkg::PH_HEAD1;
            end
            svpd_pkg::PH_LENGTH: begin
                if (rx_byte < svpd_pkg::HEADER_BYTES || rx_byte > cfg.max_length) begin
                    phase_next = svpd_pkg::PH_HEAD1;
                end else begin
                    xor_next        = rx_byte;
                    bytes_left_next = rx_byte - svpd_pkg::HEADER_BYTES;
                    phase_next      = svpd_pkg::PH_ID;
                end
            end
            svpd_pkg::PH_ID: begin
                id_next    = rx_byte;
                xor_next   = xor_payload;
                phase_next = svpd_pkg::PH_CMD;
            end
            svpd_pkg::PH_CMD: begin
                cmd_next   = rx_byte;
                xor_next   = xor_payload;
                phase_next = svpd_pkg::PH_CHECK1;
            end
            svpd_pkg::PH_CHECK1: begin
                chk1_next  = rx_byte;
                phase_next = svpd_pkg::PH_CHECK2;
            end
            svpd_pkg::PH_CHECK2: begin
                chk2_next  = rx_byte;
                phase_next = (bytes_left_reg == 8'd0) ? svpd_pkg::PH_HEAD1
                                                      : svpd_pkg::PH_PAYLOAD;
            end
            svpd_pkg::PH_PAYLOAD: begin
                xor_next        = xor_payload;
                bytes_left_next = bytes_left_reg - 8'd1;
                phase_next      = (bytes_left_reg == 8'd1) ? svpd_pkg::PH_HEAD1
                                                           : svpd_pkg::PH_PAYLOAD;
            end
            default: phase_next = svpd_pkg::PH_HEAD1;
        endcase
    end

    // Outputs
    always_comb begin
        emit                 = 1'b0;
        result.servo_id      = 8'd0;
        result.command       = 8'd0;
        result.payload_byte  = 8'd0;
        result.payload_valid = 1'b0;
        result.last          = 1'b0;
        result.status        = svpd_pkg::ST_OK;
        unique case (phase_reg)
            svpd_pkg::PH_HEAD1,
            svpd_pkg::PH_HEAD2: begin
                if (rx_byte != cfg.header_value) begin
                    emit          = 1'b1;
                    result.last   = 1'b1;
                    result.status = svpd_pkg::ST_HEADER;
                end
            end
            svpd_pkg::PH_LENGTH: begin
                if (rx_byte < svpd_pkg::HEADER_BYTES || rx_byte > cfg.max_length) begin
                    emit          = 1'b1;
                    result.last   = 1'b1;
                    result.status = svpd_pkg::ST_LENGTH;
                end
            end
            svpd_pkg::PH_CHECK2: begin
                if (bytes_left_reg == 8'd0) begin
                    emit            = 1'b1;
                    result.servo_id = id_reg;
                    result.command  = cmd_reg;
                    result.last     = 1'b1;
                    result.status   = sum_status_chk2;
                end
            end
            svpd_pkg::PH_PAYLOAD: begin
                emit                 = 1'b1;
                result.servo_id      = id_reg;
                result.command       = cmd_reg;
                result.payload_byte  = rx_byte;
                result.payload_valid = 1'b1;
                if (bytes_left_reg == 8'd1) begin
                    result.last   = 1'b1;
                    result.status = sum_status_pay;
                end
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= svpd_pkg::PH_HEAD1;
            bytes_left_reg <= 8'd0;
            xor_reg        <= 8'd0;
            id_reg         <= 8'd0;
            cmd_reg        <= 8'd0;
            chk1_reg       <= 8'd0;
            chk2_reg       <= 8'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
            id_reg         <= id_next;
            cmd_reg        <= cmd_next;
            chk1_reg       <= chk1_next;
            chk2_reg       <= chk2_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/svpd_out_fifo.sv @@
`default_nettype none

module svpd_out_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_en,
    input  wire svpd_pkg::res_t wr_data,
    input  wire logic           rd_en,
    output svpd_pkg::res_t      rd_data,
    output logic [1:0]          level
);

    svpd_pkg::res_t slot_reg [2];
    logic           head_reg, head_next;
    logic [1:0]     level_reg, level_next;
    logic           tail;

    // Writer never pushes into a full buffer; reader never pops an empty one.
    assign tail    = head_reg ^ level_reg[0];
    assign rd_data = slot_reg[head_reg];
    assign level   = level_reg;

    always_comb begin
        head_next  = head_reg ^ rd_en;
        level_next = level_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 1'b0;
            level_reg <= 2'd0;
        end else begin
            head_reg  <= head_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[tail] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/servo_packet_deframer.sv @@
`default_nettype none

// Channel   Direction  Ports                          Contents
// s_        in         s_tvalid s_tready s_tdata[7:0] rx_byte
// m_        out        m_tvalid m_tready m_tdata[23:0] servo_id, command, payload_byte
//                      m_tuser[2:0] m_tlast           payload_valid, status; last
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data   register writes
//
// One byte per cycle sustained while the output buffer has room: a byte is held
// in the input register while the framing state machine and the XOR check decide
// its result, which lands in a two-entry output buffer and leaves from there to m_.
// Reset (aresetn low, synchronous) returns to hunting for the first header byte
// and loads the register defaults. s_tready drops only when the input register
// is full and the output buffer holds two results; cfg_ready is always high.

module servo_packet_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // [7:0] servo_id, [15:8] command, [23:16] payload_byte
    output logic [2:0]       m_tuser,     // [0] payload_valid, [2:1] status
    output logic             m_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    svpd_pkg::cfg_t cfg_reg;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        emit;
    logic [1:0]  fifo_level;
    logic        pop;

    svpd_pkg::res_t result;
    svpd_pkg::res_t head_res;

    // Configuration writes; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_value <= svpd_pkg::HEADER_VALUE_RST;
            cfg_reg.check_mask   <= svpd_pkg::CHECK_MASK_RST;
            cfg_reg.max_length   <= svpd_pkg::MAX_LENGTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                svpd_pkg::REG_HEADER_VALUE: cfg_reg.header_value <= cfg_data;
                svpd_pkg::REG_CHECK_MASK:   cfg_reg.check_mask   <= cfg_data;
                svpd_pkg::REG_MAX_LENGTH:   cfg_reg.max_length   <= cfg_data;
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Advance the held byte only when the buffer has a free slot, so a
    // result is never dropped.
    assign advance  = in_vld_reg && (fifo_level != 2'd2);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    svpd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (result),
        .emit    (emit)
    );

    assign pop = m_tvalid && m_tready;

    svpd_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (advance && emit),
        .wr_data (result),
        .rd_en   (pop),
        .rd_data (head_res),
        .level   (fifo_level)
    );

    assign m_tvalid = (fifo_level != 2'd0);
    assign m_tdata  = {head_res.payload_byte, head_res.command, head_res.servo_id};
    assign m_tuser  = {head_res.status, head_res.payload_valid};
    assign m_tlast  = head_res.last;

    // The buffer never overfills.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_level != 2'd3)
        else $error("output buffer level out of range");

    // A full buffer stalls the state machine.
    a_no_adv_full: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_level == 2'd2 |-> !advance)
        else $error("advance while output buffer full");

    // Mid-packet results are payload bytes with status ok.
    a_mid_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[0] && m_tuser[2:1] == svpd_pkg::ST_OK)
        else $error("non-final result without payload or with status");

    // No payload flag means a zero payload byte.
    a_empty_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[23:16] == 8'd0 && m_tlast)
        else $error("result without payload is not a clean final result");

endmodule

`default_nettype wire

@@ test/servo_packet_deframer_check.sv @@
`timescale 1ns / 100ps

module servo_packet_deframer_check
    import svpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    output int          fail_count,
    output int          pending
);

    // Shadow of the framer state and registers
    phase_t     hunt_phase;
    logic [7:0] remaining;
    logic [7:0] xor_acc;
    logic [7:0] id_hold;
    logic [7:0] cmd_hold;
    logic [7:0] chk1_hold;
    logic [7:0] chk2_hold;
    cfg_t       live_cfg;

    res_t       due_results[$];

    function automatic status_t sum_status();
        logic [7:0] want1;
        logic [7:0] want2;
        want1 = xor_acc & live_cfg.check_mask;
        want2 = ~xor_acc & live_cfg.check_mask;
        return (want1 == chk1_hold && want2 == chk2_hold) ? ST_OK : ST_CHECKSUM;
    endfunction

    // Advance the framer by one received byte; hit flags a result.
    function automatic void deframe_byte(input logic [7:0] b, output bit hit,
                                         output res_t r);
        hit = 1'b0;
        r   = '0;
        case (hunt_phase)
            PH_HEAD1, PH_HEAD2: begin
                if (b != live_cfg.header_value) begin
                    hunt_phase = PH_HEAD1;
                    r.last     = 1'b1;
                    r.status   = ST_HEADER;
                    hit        = 1'b1;
                end else if (hunt_phase == PH_HEAD1) begin
                    hunt_phase = PH_HEAD2;
                end else begin
                    hunt_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (b < HEADER_BYTES || b > live_cfg.max_length) begin
                    hunt_phase = PH_HEAD1;
                    r.last     = 1'b1;
                    r.status   = ST_LENGTH;
                    hit        = 1'b1;
                end else begin
                    xor_acc    = b;
                    remaining  = b - HEADER_BYTES;
                    hunt_phase = PH_ID;
                end
            end
            PH_ID: begin
                id_hold    = b;
                xor_acc    = xor_acc ^ b;
                hunt_phase = PH_CMD;
            end
            PH_CMD: begin
                cmd_hold   = b;
                xor_acc    = xor_acc ^ b;
                hunt_phase = PH_CHECK1;
            end
            PH_CHECK1: begin
                chk1_hold  = b;
                hunt_phase = PH_CHECK2;
            end
            PH_CHECK2: begin
                chk2_hold = b;
                if (remaining == 8'd0) begin
                    hunt_phase = PH_HEAD1;
                    r.servo_id = id_hold;
                    r.command  = cmd_hold;
                    r.last     = 1'b1;
                    r.status   = sum_status();
                    hit        = 1'b1;
                end else begin
                    hunt_phase = PH_PAYLOAD;
                end
            end
            default: begin
                xor_acc         = xor_acc ^ b;
                remaining       = remaining - 8'd1;
                r.servo_id      = id_hold;
                r.command       = cmd_hold;
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                hit             = 1'b1;
                if (remaining == 8'd0) begin
                    hunt_phase = PH_HEAD1;
                    r.last     = 1'b1;
                    r.status   = sum_status();
                end
            end
        endcase
    endfunction

    task automatic match_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        bit   hit;
        res_t guess;
        res_t head;
        if (!aresetn) begin
            hunt_phase = PH_HEAD1;
            remaining  = '0;
            xor_acc    = '0;
            id_hold    = '0;
            cmd_hold   = '0;
            chk1_hold  = '0;
            chk2_hold  = '0;
            live_cfg   = '{HEADER_VALUE_RST, CHECK_MASK_RST, MAX_LENGTH_RST};
            due_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HEADER_VALUE: live_cfg.header_value = cfg_data;
                    REG_CHECK_MASK:   live_cfg.check_mask   = cfg_data;
                    REG_MAX_LENGTH:   live_cfg.max_length   = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, hit, guess);
                if (hit)
                    due_results = {due_results, guess};
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $display("%0t ns: extra result, expected none actual %06h/%0h/%0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    head = due_results.pop_front();
                    match_field("servo_id", int'(head.servo_id), int'(m_tdata[7:0]));
                    match_field("command", int'(head.command), int'(m_tdata[15:8]));
                    match_field("payload_byte", int'(head.payload_byte),
                                int'(m_tdata[23:16]));
                    match_field("payload_valid", int'(head.payload_valid),
                                int'(m_tuser[0]));
                    match_field("last", int'(head.last), int'(m_tlast));
                    match_field("status", int'(head.status), int'(m_tuser[2:1]));
                end
            end
        end
        pending = due_results.size();
    end

endmodule

@@ test/servo_packet_deframer_test.sv @@
`timescale 1ns / 100ps

module servo_packet_deframer_test;
    import svpd_pkg::*;

    // Watchdog, well above the slowest legal run of roughly 2000 bytes with the
    // longest idle gap before each byte plus the longest stall before each result.
    localparam int LIMIT     = 500000;
    localparam int ITEM_GOAL = 1700;
    localparam int PHASE_LEN = 220;
    // Cycles to let a quiet byte clear the two-stage pipeline before a
    // register write or the verdict.
    localparam int SETTLE    = 6;
    localparam int FULL      = 1 << 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;           // [7:0] rx_byte

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;                // [7:0] servo_id, [15:8] command, [23:16] payload_byte
    logic [2:0]  m_tuser;                // [0] payload_valid, [2:1] status
    logic        m_tlast;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    int          fail_count;
    int          pending;

    int          cycles = 0;
    int          items_sent = 0;
    bit          no_gaps = 1'b0;

    // Register values as last written, used to build well-formed frames
    logic [7:0]  hdr_val  = HEADER_VALUE_RST;
    logic [7:0]  mask_val = CHECK_MASK_RST;
    logic [7:0]  max_len  = MAX_LENGTH_RST;

    logic [7:0]  frame_body[$];

    servo_packet_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    servo_packet_deframer_check frame_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle or stall length for one transaction; zero in burst phases
    function automatic int hold_cycles();
        return no_gaps ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Offer one byte and hold it until accepted. Called and returns on a
    // falling edge; the caller either offers the next byte at once or drops
    // tvalid, so tvalid sees one assignment per step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = hold_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    // Drop tvalid and wait for every outstanding result, then let the
    // pipeline empty of bytes that cause no result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // One write transaction; leaves cfg_valid high for a following write.
    task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write all three registers back to back; only call while drained.
    task automatic set_config(input logic [7:0] hdr, input logic [7:0] mask,
                              input logic [7:0] maxl);
        put_reg(REG_HEADER_VALUE, hdr);
        put_reg(REG_CHECK_MASK, mask);
        put_reg(REG_MAX_LENGTH, maxl);
        cfg_valid <= 1'b0;
        hdr_val  = hdr;
        mask_val = mask;
        max_len  = maxl;
    endtask

    // Send a frame around frame_body under the current registers. spoil
    // flips one bit of a check byte; keep cuts the frame after that many
    // bytes, leaving the framer mid-packet.
    task automatic send_frame(input logic [7:0] id, input logic [7:0] cmd,
                              input bit spoil, input int keep);
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] wire_bytes[$];
        len = 8'(frame_body.size() + HEADER_BYTES);
        sum = len ^ id ^ cmd;
        foreach (frame_body[k]) sum = sum ^ frame_body[k];
        c1 = sum & mask_val;
        c2 = ~sum & mask_val;
        if (spoil) begin
            if ($urandom_range(0, 1))
                c1 = c1 ^ (8'd1 << $urandom_range(0, 7));
            else
                c2 = c2 ^ (8'd1 << $urandom_range(0, 7));
        end
        wire_bytes = {hdr_val, hdr_val, len, id, cmd, c1, c2};
        foreach (frame_body[k]) wire_bytes = {wire_bytes, frame_body[k]};
        for (int k = 0; k < wire_bytes.size() && k < keep; k++)
            send_byte(wire_bytes[k]);
    endtask

    // Mostly short payloads, now and then the longest one max_length allows
    function automatic int body_len();
        int max_n;
        max_n = int'(max_len) - int'(HEADER_BYTES);
        if ($urandom_range(0, 39) == 0)
            return max_n;
        return int'($urandom_range(0, (max_n < 12) ? max_n : 12));
    endfunction

    task automatic fill_body(input int n);
        frame_body.delete();
        repeat (n) frame_body = {frame_body, 8'($urandom_range(0, 255))};
    endtask

    // One random unit: mostly well-formed frames, the rest broken framing
    task automatic random_unit();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            fill_body(body_len());
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom_range(0, 5) == 0, FULL);
        end else if (pick < 78) begin
            send_byte(hdr_val);
            send_byte(hdr_val);
            if (max_len == 8'hFF || $urandom_range(0, 1))
                send_byte(8'($urandom_range(0, HEADER_BYTES - 1)));
            else
                send_byte(8'($urandom_range(int'(max_len) + 1, 255)));
        end else if (pick < 86) begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 93) begin
            n = body_len();
            fill_body(n);
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                       $urandom_range(1, n + HEADER_BYTES - 1));
        end else begin
            send_byte(hdr_val);
            send_byte(hdr_val ^ (8'd1 << $urandom_range(0, 7)));
        end
    endtask

    // Receiver: stall a random number of cycles before each result
    initial begin : result_sink
        int stall;
        @(negedge aclk);
        forever begin
            stall = hold_cycles();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int goal;
        int phase_end;
        int phase_no;
        logic [7:0] hdr;
        logic [7:0] mask;
        logic [7:0] maxl;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, at reset values: empty payload that checks out
        frame_body.delete();
        send_frame(8'h00, 8'h00, 1'b0, FULL);
        // extreme payload bytes with a broken check byte
        frame_body.delete();
        frame_body = {frame_body, 8'h00};
        frame_body = {frame_body, 8'hFF};
        send_frame(8'hFF, 8'hFF, 1'b1, FULL);
        // wrong first header byte
        send_byte(8'h00);
        // wrong second header byte
        send_byte(8'hFF);
        send_byte(8'h7F);
        // length below the fixed part
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(HEADER_BYTES - 8'd1);

        // Smallest max_length: anything longer than the fixed part is bad
        drain();
        set_config(8'h00, 8'hFF, HEADER_BYTES);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(HEADER_BYTES + 8'd1);

        // Random phases, each under fresh register values
        goal = items_sent + ITEM_GOAL;
        phase_no = 0;
        while (items_sent < goal) begin
            // hold off until every result of the last phase has arrived
            drain();
            if (phase_no == 0) begin
                hdr  = 8'hFF;
                mask = 8'h00;
                maxl = 8'hFF;
            end else begin
                case ($urandom_range(0, 3))
                    0:       hdr = 8'h00;
                    1:       hdr = 8'hFF;
                    default: hdr = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 3))
                    0:       mask = 8'h00;
                    1:       mask = 8'hFF;
                    default: mask = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 3))
                    0:       maxl = HEADER_BYTES;
                    1:       maxl = 8'hFF;
                    2:       maxl = 8'($urandom_range(8, 30));
                    default: maxl = 8'($urandom_range(HEADER_BYTES, 255));
                endcase
            end
            set_config(hdr, mask, maxl);
            // every fourth phase runs both sides without idling
            no_gaps = (phase_no % 4 == 3);
            phase_end = items_sent + PHASE_LEN;
            while (items_sent < phase_end && items_sent < goal)
                random_unit();
            phase_no++;
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
